/* hdl/tmd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Threshold median denoise package
// Widths, register indexes, shared item types and the depths of the line
// store and the queue between the front and back parts.
// ----------------------------------------------------------------------------
package tmd_pkg;

   localparam int PIX_W       = 8;
   localparam int POS_W       = 12;
   localparam int DIM_W       = 13;
   localparam int MAX_DIM     = 4096;
   localparam int LINE_DEPTH  = 4096;
   localparam int LINE_AW     = $clog2(LINE_DEPTH);
   localparam int WIN_SIDE    = 3;
   localparam int WIN_AREA    = WIN_SIDE * WIN_SIDE;
   localparam int WIN_CENTRE  = WIN_AREA / 2;
   localparam int WIN_IDX_W   = $clog2(WIN_AREA);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 2;
   localparam int RSP_W       = PIX_W + 2 * POS_W;

   localparam logic [DIM_W-1:0]   DIM_ONE    = DIM_W'(1);
   localparam logic [DIM_W-1:0]   DIM_MAX    = DIM_W'(MAX_DIM);
   localparam logic [POS_W-1:0]   POS_ONE    = POS_W'(1);
   localparam logic [POS_W-1:0]   POS_TWO    = POS_W'(2);
   localparam logic [LEVEL_W-1:0] QUEUE_FULL = LEVEL_W'(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 2'd2;

   localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd0;
   localparam logic [DIM_W-1:0] WIDTH_RESET     = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET    = 13'd480;

   typedef logic [WIN_AREA-1:0][PIX_W-1:0] win_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             border;
      logic             interior;
      win_type          win;
   } item_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             border;
      logic             interior;
      logic [PIX_W-1:0] centre;
   } meta_type;

endpackage
`default_nettype wire

/* hdl/tmd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Threshold median denoise front
// Accepts pixels, tracks the raster position, classifies each pixel as
// border and/or interior, keeps the two line stores and the 3x3 window, and
// pushes items that cause results into the queue.
// ----------------------------------------------------------------------------
module tmd_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [tmd_pkg::PIX_W-1:0]     req_tdata,
   input  wire logic [tmd_pkg::DIM_W-1:0]     frame_width,
   input  wire logic [tmd_pkg::DIM_W-1:0]     frame_height,
   input  wire logic [tmd_pkg::LEVEL_W-1:0]   queue_level,
   output logic                               push_valid,
   output tmd_pkg::item_type                  push_item
);

   logic [tmd_pkg::DIM_W-1:0]   width_eff;
   logic [tmd_pkg::DIM_W-1:0]   height_eff;
   logic [tmd_pkg::DIM_W-1:0]   row_next;
   logic [tmd_pkg::DIM_W-1:0]   col_next;
   logic                        accept;
   logic                        border;
   logic                        interior;
   logic [tmd_pkg::LINE_AW-1:0] line_addr;

   logic [tmd_pkg::POS_W-1:0]   row_ff, row_in;
   logic [tmd_pkg::POS_W-1:0]   col_ff, col_in;
   logic                        f1_valid_ff, f1_valid_in;
   logic [tmd_pkg::PIX_W-1:0]   f1_pix_ff;
   logic [tmd_pkg::POS_W-1:0]   f1_row_ff;
   logic [tmd_pkg::POS_W-1:0]   f1_col_ff;
   logic                        f1_border_ff;
   logic                        f1_interior_ff;
   logic [tmd_pkg::PIX_W-1:0]   rd0_ff;
   logic [tmd_pkg::PIX_W-1:0]   rd1_ff;
   logic [tmd_pkg::PIX_W-1:0]   line0_ff [tmd_pkg::LINE_DEPTH];
   logic [tmd_pkg::PIX_W-1:0]   line1_ff [tmd_pkg::LINE_DEPTH];
   tmd_pkg::win_type            win_ff, win_in;
   logic [tmd_pkg::PIX_W-1:0]   same_row;
   logic [tmd_pkg::PIX_W-1:0]   other_row;
   tmd_pkg::win_type            win_shift;

   always_comb begin
      if (frame_width == '0) begin
         width_eff = tmd_pkg::DIM_ONE;
      end else if (frame_width > tmd_pkg::DIM_MAX) begin
         width_eff = tmd_pkg::DIM_MAX;
      end else begin
         width_eff = frame_width;
      end
      if (frame_height == '0) begin
         height_eff = tmd_pkg::DIM_ONE;
      end else if (frame_height > tmd_pkg::DIM_MAX) begin
         height_eff = tmd_pkg::DIM_MAX;
      end else begin
         height_eff = frame_height;
      end
   end

   assign req_tready = ({1'b0, queue_level} + {{tmd_pkg::LEVEL_W{1'b0}}, f1_valid_ff})
                       < {1'b0, tmd_pkg::QUEUE_FULL};
   assign accept     = req_tvalid & req_tready;
   assign row_next   = {1'b0, row_ff} + tmd_pkg::DIM_ONE;
   assign col_next   = {1'b0, col_ff} + tmd_pkg::DIM_ONE;
   assign line_addr  = col_ff[tmd_pkg::LINE_AW-1:0];

   assign border   = (row_ff == '0) || (col_ff == '0) ||
                     (row_next >= height_eff) || (col_next >= width_eff);
   assign interior = (row_ff >= tmd_pkg::POS_TWO) && (col_ff >= tmd_pkg::POS_TWO) &&
                     ({1'b0, row_ff} < height_eff) && ({1'b0, col_ff} < width_eff);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_next >= width_eff) begin
            col_in = '0;
            row_in = (row_next >= height_eff) ? '0 : row_next[tmd_pkg::POS_W-1:0];
         end else begin
            col_in = col_next[tmd_pkg::POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd0_ff <= line0_ff[line_addr];
         if (!row_ff[0]) begin
            line0_ff[line_addr] <= req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd1_ff <= line1_ff[line_addr];
         if (row_ff[0]) begin
            line1_ff[line_addr] <= req_tdata;
         end
      end
   end

   assign same_row  = f1_row_ff[0] ? rd1_ff : rd0_ff;
   assign other_row = f1_row_ff[0] ? rd0_ff : rd1_ff;

   always_comb begin
      win_shift = win_ff;
      for (int r = 0; r < tmd_pkg::WIN_SIDE; r++) begin
         win_shift[r * tmd_pkg::WIN_SIDE]     = win_ff[r * tmd_pkg::WIN_SIDE + 1];
         win_shift[r * tmd_pkg::WIN_SIDE + 1] = win_ff[r * tmd_pkg::WIN_SIDE + 2];
      end
      win_shift[tmd_pkg::WIN_SIDE - 1]     = same_row;
      win_shift[2 * tmd_pkg::WIN_SIDE - 1] = other_row;
      win_shift[tmd_pkg::WIN_AREA - 1]     = f1_pix_ff;
   end

   assign win_in      = f1_valid_ff ? win_shift : win_ff;
   assign f1_valid_in = accept;

   assign push_valid         = f1_valid_ff & (f1_border_ff | f1_interior_ff);
   assign push_item.pix      = f1_pix_ff;
   assign push_item.row      = f1_row_ff;
   assign push_item.col      = f1_col_ff;
   assign push_item.border   = f1_border_ff;
   assign push_item.interior = f1_interior_ff;
   assign push_item.win      = win_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         f1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         f1_valid_ff <= f1_valid_in;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_pix_ff      <= req_tdata;
         f1_row_ff      <= row_ff;
         f1_col_ff      <= col_ff;
         f1_border_ff   <= border;
         f1_interior_ff <= interior;
      end
   end

endmodule
`default_nettype wire

/* hdl/tmd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Threshold median denoise queue
// Short first-in first-out buffer of classified items between the front and
// the back, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module tmd_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push_valid,
   input  wire tmd_pkg::item_type            push_item,
   input  wire logic                         pop,
   output logic                              head_valid,
   output tmd_pkg::item_type                 head_item,
   output logic [tmd_pkg::LEVEL_W-1:0]       level
);

   tmd_pkg::item_type                 slots_ff [tmd_pkg::QUEUE_DEPTH];
   logic [tmd_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tmd_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tmd_pkg::LEVEL_W-1:0]       level_ff, level_in;

   assign head_valid = (level_ff != '0);
   assign head_item  = slots_ff[rd_ptr_ff];
   assign level      = level_ff;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (push_valid && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push_valid) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (level_ff != tmd_pkg::QUEUE_FULL))
      else $error("Queue written while full.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (level_ff != '0))
      else $error("Queue read while empty.");
`endif

endmodule
`default_nettype wire

/* hdl/tmd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Threshold median denoise back
// Three-stage median network over the 3x3 window, the keep-or-replace
// decision, and an output register that sends the border copy and the
// filtered interior pixel of an item as separate beats.
// ----------------------------------------------------------------------------
module tmd_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire tmd_pkg::item_type             head_item,
   output logic                               pop,
   input  wire logic [tmd_pkg::PIX_W-1:0]     noise_threshold,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [tmd_pkg::RSP_W-1:0]          rsp_tdata,
   output logic                               rsp_tlast
);

   function automatic tmd_pkg::win_type sort2(input tmd_pkg::win_type v,
                                              input logic [tmd_pkg::WIN_IDX_W-1:0] lo,
                                              input logic [tmd_pkg::WIN_IDX_W-1:0] hi);
      tmd_pkg::win_type r;
      r = v;
      if (v[lo] > v[hi]) begin
         r[lo] = v[hi];
         r[hi] = v[lo];
      end
      return r;
   endfunction

   function automatic tmd_pkg::win_type layers_a(input tmd_pkg::win_type v);
      tmd_pkg::win_type r;
      r = sort2(v, 4'd1, 4'd2);
      r = sort2(r, 4'd4, 4'd5);
      r = sort2(r, 4'd7, 4'd8);
      r = sort2(r, 4'd0, 4'd1);
      r = sort2(r, 4'd3, 4'd4);
      r = sort2(r, 4'd6, 4'd7);
      r = sort2(r, 4'd1, 4'd2);
      r = sort2(r, 4'd4, 4'd5);
      r = sort2(r, 4'd7, 4'd8);
      return r;
   endfunction

   function automatic tmd_pkg::win_type layers_b(input tmd_pkg::win_type v);
      tmd_pkg::win_type r;
      r = sort2(v, 4'd0, 4'd3);
      r = sort2(r, 4'd5, 4'd8);
      r = sort2(r, 4'd4, 4'd7);
      r = sort2(r, 4'd3, 4'd6);
      r = sort2(r, 4'd1, 4'd4);
      r = sort2(r, 4'd2, 4'd5);
      r = sort2(r, 4'd4, 4'd7);
      return r;
   endfunction

   function automatic tmd_pkg::win_type layers_c(input tmd_pkg::win_type v);
      tmd_pkg::win_type r;
      r = sort2(v, 4'd4, 4'd2);
      r = sort2(r, 4'd6, 4'd4);
      r = sort2(r, 4'd4, 4'd2);
      return r;
   endfunction

   logic                          advance;
   logic                          load_emit;
   tmd_pkg::meta_type             head_meta;
   tmd_pkg::win_type              med_win;
   logic [tmd_pkg::PIX_W-1:0]     diff;
   logic [tmd_pkg::PIX_W-1:0]     filtered;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s2_valid_ff, s2_valid_in;
   logic                          s3_valid_ff, s3_valid_in;
   tmd_pkg::meta_type             s1_meta_ff;
   tmd_pkg::meta_type             s2_meta_ff;
   tmd_pkg::meta_type             s3_meta_ff;
   tmd_pkg::win_type              s1_win_ff;
   tmd_pkg::win_type              s2_win_ff;
   logic [tmd_pkg::PIX_W-1:0]     s3_med_ff;

   logic                          bp_ff, bp_in;
   logic                          ip_ff, ip_in;
   tmd_pkg::meta_type             em_meta_ff;
   logic [tmd_pkg::PIX_W-1:0]     em_filt_ff;
   logic [tmd_pkg::POS_W-1:0]     em_row;
   logic [tmd_pkg::POS_W-1:0]     em_col;

   assign advance   = !(bp_ff | ip_ff) | (rsp_tready & (bp_ff ^ ip_ff));
   assign pop       = advance & head_valid;
   assign load_emit = advance & s3_valid_ff;

   assign head_meta.pix      = head_item.pix;
   assign head_meta.row      = head_item.row;
   assign head_meta.col      = head_item.col;
   assign head_meta.border   = head_item.border;
   assign head_meta.interior = head_item.interior;
   assign head_meta.centre   = head_item.win[tmd_pkg::WIN_CENTRE];

   assign med_win = layers_c(s2_win_ff);

   assign s1_valid_in = advance ? head_valid  : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = advance ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_meta_ff <= head_meta;
         s1_win_ff  <= layers_a(head_item.win);
         s2_meta_ff <= s1_meta_ff;
         s2_win_ff  <= layers_b(s1_win_ff);
         s3_meta_ff <= s2_meta_ff;
         s3_med_ff  <= med_win[tmd_pkg::WIN_CENTRE];
      end
   end

   assign diff     = (s3_meta_ff.centre > s3_med_ff) ? s3_meta_ff.centre - s3_med_ff
                                                     : s3_med_ff - s3_meta_ff.centre;
   assign filtered = (diff <= noise_threshold) ? s3_meta_ff.centre : s3_med_ff;

   always_comb begin
      bp_in = bp_ff;
      ip_in = ip_ff;
      if (load_emit) begin
         bp_in = s3_meta_ff.border;
         ip_in = s3_meta_ff.interior;
      end else if (advance) begin
         bp_in = 1'b0;
         ip_in = 1'b0;
      end else if (rsp_tready) begin
         bp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_emit) begin
         em_meta_ff <= s3_meta_ff;
         em_filt_ff <= filtered;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         bp_ff       <= 1'b0;
         ip_ff       <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         bp_ff       <= bp_in;
         ip_ff       <= ip_in;
      end
   end

   assign em_row     = em_meta_ff.row - tmd_pkg::POS_ONE;
   assign em_col     = em_meta_ff.col - tmd_pkg::POS_ONE;
   assign rsp_tvalid = bp_ff | ip_ff;
   assign rsp_tlast  = bp_ff ? !ip_ff : 1'b1;
   assign rsp_tdata  = bp_ff ? {em_meta_ff.col, em_meta_ff.row, em_meta_ff.pix}
                             : {em_col, em_row, em_filt_ff};

`ifndef SYNTHESIS
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tlast))
      else $error("Second result of an item did not follow the border copy.");

   a_interior_pos: assert property (@(posedge clock) disable iff (reset)
      (ip_ff && !bp_ff) |-> ((em_meta_ff.row != '0) && (em_meta_ff.col != '0)))
      else $error("Interior result at a position with no upper-left neighbor.");
`endif

endmodule
`default_nettype wire

/* hdl/threshold_median_denoise.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Threshold median denoise
// Switching 3x3 median filter over a raster pixel stream: border pixels are
// copied, interior pixels keep their value unless it differs from the window
// median by more than the threshold, in which case the median replaces it.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// req_      in         pixel_in
// rsp_      out        pixel_out, out_row, out_col; tlast = last_of_input
// csr_      in         register write (0 threshold, 1 width, 2 height)
//
// One pixel is accepted per clock while the queue has room; an item with both a
// border copy and an interior result needs two output beats, and the four-entry
// queue absorbs it. An accepted pixel passes the line store read, the window,
// the queue, three median stages and the output register to its first result.
// Reset is synchronous; the line store is not cleared and holds stale data.
// A stalled output stops the median stages; input stalls once the queue fills.
// ----------------------------------------------------------------------------
module threshold_median_denoise (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [tmd_pkg::PIX_W-1:0]      req_tdata,   // [7:0] pixel_in
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [tmd_pkg::RSP_W-1:0]           rsp_tdata,   // [7:0] pixel_out,
                                                            // [19:8] out_row,
                                                            // [31:20] out_col
   output logic                                rsp_tlast,
   input  wire logic                           csr_we,
   input  wire logic [tmd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tmd_pkg::DIM_W-1:0]      csr_wdata
);

   logic [tmd_pkg::PIX_W-1:0]     threshold_ff, threshold_in;
   logic [tmd_pkg::DIM_W-1:0]     width_ff, width_in;
   logic [tmd_pkg::DIM_W-1:0]     height_ff, height_in;

   logic                          push_valid;
   tmd_pkg::item_type             push_item;
   logic                          pop;
   logic                          head_valid;
   tmd_pkg::item_type             head_item;
   logic [tmd_pkg::LEVEL_W-1:0]   queue_level;

   always_comb begin
      threshold_in = threshold_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            tmd_pkg::CSR_THRESHOLD: begin
               threshold_in = csr_wdata[tmd_pkg::PIX_W-1:0];
            end
            tmd_pkg::CSR_WIDTH: begin
               width_in = csr_wdata;
            end
            tmd_pkg::CSR_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tmd_pkg::THRESHOLD_RESET;
         width_ff     <= tmd_pkg::WIDTH_RESET;
         height_ff    <= tmd_pkg::HEIGHT_RESET;
      end else begin
         threshold_ff <= threshold_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   tmd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .queue_level  (queue_level),
      .push_valid   (push_valid),
      .push_item    (push_item)
   );

   tmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .level      (queue_level)
   );

   tmd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .noise_threshold (threshold_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast)
   );

endmodule
`default_nettype wire

/* test/threshold_median_denoise_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Threshold median denoise checker
// Watches the pixel, result and register ports of the denoiser. It keeps its
// own line memory, 3x3 window and raster position and works out the beats
// each accepted pixel should cause. It then compares every result beat,
// field by field, with the oldest beat still due.
// ----------------------------------------------------------------------------
module threshold_median_denoise_check (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [tmd_pkg::PIX_W-1:0]      req_tdata,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [tmd_pkg::RSP_W-1:0]      rsp_tdata,
   input  wire logic                           rsp_tlast,
   input  wire logic                           csr_we,
   input  wire logic [tmd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tmd_pkg::DIM_W-1:0]      csr_wdata,
   output int                                  errors,
   output int                                  outstanding
);
   import tmd_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } beat_type;

   logic [PIX_W-1:0] line_mem [0:2*LINE_DEPTH-1];
   logic [PIX_W-1:0] win [0:WIN_AREA-1];
   logic [PIX_W-1:0] threshold;
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   int               row_pos;
   int               col_pos;
   beat_type         pixels_due [$];

   task automatic flag_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
   endtask

   function automatic int clamp_dim(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (v > DIM_MAX) begin
         return MAX_DIM;
      end
      return int'(v);
   endfunction

   function automatic bit on_edge(input int r, input int c, input int h, input int w);
      return r < 1 || c < 1 || r + 1 >= h || c + 1 >= w;
   endfunction

   function automatic logic [PIX_W-1:0] window_median();
      logic [PIX_W-1:0] v [0:WIN_AREA-1];
      logic [PIX_W-1:0] t;
      int               j;
      for (int i = 0; i < WIN_AREA; i++) begin
         v[i] = win[i];
      end
      for (int i = 1; i < WIN_AREA; i++) begin
         t = v[i];
         j = i;
         while (j > 0 && v[j-1] > t) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = t;
      end
      return v[WIN_CENTRE];
   endfunction

   // Shifts the window, updates the line memory and queues the border copy of
   // the new pixel and then the interior pixel one row up and one column left.
   task automatic filter_pixel(input logic [PIX_W-1:0] pix);
      int               w;
      int               h;
      int               r;
      int               c;
      int               near;
      int               far;
      bit               copy;
      bit               late;
      logic [PIX_W-1:0] centre;
      logic [PIX_W-1:0] med;
      logic [PIX_W-1:0] diff;
      beat_type         due;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      r = row_pos;
      c = col_pos;
      near = (r % 2) * LINE_DEPTH + c % LINE_DEPTH;
      far = ((r + 1) % 2) * LINE_DEPTH + c % LINE_DEPTH;
      for (int k = 0; k < WIN_SIDE; k++) begin
         win[k*WIN_SIDE] = win[k*WIN_SIDE+1];
         win[k*WIN_SIDE+1] = win[k*WIN_SIDE+2];
      end
      win[2] = line_mem[near];
      win[5] = line_mem[far];
      win[8] = pix;
      line_mem[near] = pix;

      copy = on_edge(r, c, h, w);
      late = r >= 1 && c >= 1 && !on_edge(r - 1, c - 1, h, w);
      if (copy) begin
         due.pix = pix;
         due.row = POS_W'(r);
         due.col = POS_W'(c);
         due.last = !late;
         pixels_due.push_back(due);
      end
      if (late) begin
         centre = win[WIN_CENTRE];
         med = window_median();
         diff = centre > med ? centre - med : med - centre;
         due.pix = diff <= threshold ? centre : med;
         due.row = POS_W'(r - 1);
         due.col = POS_W'(c - 1);
         due.last = 1'b1;
         pixels_due.push_back(due);
      end

      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = r + 1 >= h ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin : watch
      beat_type got;
      beat_type want;
      if (reset) begin
         threshold = THRESHOLD_RESET;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         row_pos = 0;
         col_pos = 0;
         for (int i = 0; i < WIN_AREA; i++) begin
            win[i] = '0;
         end
         for (int i = 0; i < 2 * LINE_DEPTH; i++) begin
            line_mem[i] = '0;
         end
         pixels_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_THRESHOLD: begin
                  threshold = csr_wdata[PIX_W-1:0];
               end
               CSR_WIDTH: begin
                  width_reg = csr_wdata;
               end
               CSR_HEIGHT: begin
                  height_reg = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            filter_pixel(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.pix = rsp_tdata[PIX_W-1:0];
            got.row = rsp_tdata[PIX_W+POS_W-1:PIX_W];
            got.col = rsp_tdata[RSP_W-1:PIX_W+POS_W];
            got.last = rsp_tlast;
            if (pixels_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat pixel %0d row %0d col %0d",
                                       got.pix, got.row, got.col));
            end else begin
               want = pixels_due.pop_front();
               if (got.pix !== want.pix) begin
                  flag_mismatch($sformatf("pixel_out %0d, expected %0d (row %0d col %0d)",
                                          got.pix, want.pix, want.row, want.col));
               end
               if (got.row !== want.row) begin
                  flag_mismatch($sformatf("out_row %0d, expected %0d",
                                          got.row, want.row));
               end
               if (got.col !== want.col) begin
                  flag_mismatch($sformatf("out_col %0d, expected %0d",
                                          got.col, want.col));
               end
               if (got.last !== want.last) begin
                  flag_mismatch($sformatf("tlast %0b, expected %0b (row %0d col %0d)",
                                          got.last, want.last, want.row, want.col));
               end
            end
         end
      end
      outstanding = pixels_due.size();
   end

endmodule

/* test/threshold_median_denoise_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Threshold median denoise testbench
// Streams frames of pixels into the denoiser through its register port
// settings: a hand-made frame, clamped frame sizes with part of a wide row
// and part of a tall column, a size change in the middle of a frame and then
// many small random frames of smooth images with impulse noise. Both
// channels idle at random, and the result side now and then holds off long
// enough to stall the input. The checker beside the block predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module threshold_median_denoise_tb;
   import tmd_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_PIXELS = 1450;
   localparam int SETTLE_CYCLES = 16;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_THRESHOLD;
   logic [DIM_W-1:0]     csr_wdata = '0;

   int                   errors;
   int                   outstanding;
   int                   quiet;
   bit                   sender_lazy;
   bit                   receiver_lazy;
   int                   noise_kind;
   logic [PIX_W-1:0]     base_level;

   logic [PIX_W-1:0] pattern [0:19] = '{
      8'd0,   8'd255, 8'd128, 8'd127, 8'd1,
      8'd100, 8'd255, 8'd100, 8'd0,   8'd100,
      8'd100, 8'd100, 8'd101, 8'd100, 8'd254,
      8'd2,   8'd4,   8'd8,   8'd16,  8'd32
   };

   always #10 clock = ~clock;

   threshold_median_denoise u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   threshold_median_denoise_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .errors      (errors),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin : watchdog
      wait (quiet >= QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // Once every 700 beats the result side waits until pixels are offered
   // and then holds off for a long stretch, so that the queue fills and the
   // pixel input stalls.
   initial begin : drain
      int gap;
      int beats;
      beats = 0;
      receiver_lazy = 1'b1;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         gap = receiver_lazy ? $urandom_range(0, 9) : 0;
         if (beats % 700 == 350) begin
            while (!req_tvalid) begin
               @(negedge clock);
            end
            gap = 150;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) begin
            @(posedge clock);
         end
         beats++;
         if (beats % 50 == 0) begin
            receiver_lazy = $urandom_range(0, 2) != 0;
         end
         @(negedge clock);
      end
   end

   function automatic logic [PIX_W-1:0] next_pixel();
      int roll;
      roll = $urandom_range(0, 99);
      if (noise_kind == 0 || roll < 5) begin
         return PIX_W'($urandom_range(0, 255));
      end
      if (roll < 15) begin
         return roll[0] ? 8'd255 : 8'd0;
      end
      return base_level + PIX_W'($urandom_range(0, 12)) - 8'd6;
   endfunction

   function automatic logic [PIX_W-1:0] pick_threshold();
      case ($urandom_range(0, 4))
         0: return 8'd0;
         1: return 8'd255;
         2, 3: return PIX_W'($urandom_range(0, 24));
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      gap = sender_lazy ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic send_frame(input int count);
      for (int i = 0; i < count; i++) begin
         send_pixel(next_pixel());
      end
   endtask

   // The last pixel sent may cause no result, so the block is given its
   // pipeline latency on top of the wait for the last result.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [PIX_W-1:0] thr, input logic [DIM_W-1:0] w,
                            input logic [DIM_W-1:0] h);
      csr_we <= 1'b1;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= DIM_W'(thr);
      @(negedge clock);
      csr_index <= CSR_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int  random_sent;
      int  fw;
      int  fh;
      bit  first;
      random_sent = 0;
      first = 1'b1;
      sender_lazy = 1'b1;
      noise_kind = 1;
      base_level = 8'd128;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Hand-made 5x4 frame with a zero threshold, then a 1x1 frame from
      // zero sizes that clamp to one.
      configure(8'd0, 13'd5, 13'd4);
      for (int i = 0; i < 20; i++) begin
         send_pixel(pattern[i]);
      end
      settle();
      configure(8'd37, 13'd0, 13'd0);
      send_pixel(8'd200);
      settle();

      // Over-range sizes clamp to 4096: part of a wide row and part of a
      // tall column, each finished under a small frame size.
      noise_kind = 0;
      configure(8'd255, 13'h1FFF, 13'd1);
      send_frame(100);
      settle();
      noise_kind = 1;
      configure(pick_threshold(), 13'd5, 13'd3);
      send_frame(11);
      settle();
      configure(pick_threshold(), 13'd1, 13'h1FFF);
      send_frame(100);
      settle();
      configure(pick_threshold(), 13'd5, 13'd3);
      send_frame(5);
      settle();

      // Size change in the middle of a frame: the row is already past the
      // new height, so the frame ends with the current row of the new width.
      configure(pick_threshold(), 13'd8, 13'd8);
      send_frame(19);
      settle();
      configure(pick_threshold(), 13'd5, 13'd2);
      send_frame(2);

      while (random_sent < RANDOM_PIXELS) begin
         if (first || $urandom_range(0, 2) != 0) begin
            settle();
            fw = $urandom_range(0, 5) == 0 ? $urandom_range(1, 16) : $urandom_range(3, 8);
            fh = $urandom_range(0, 5) == 0 ? $urandom_range(1, 12) : $urandom_range(3, 7);
            configure(pick_threshold(), DIM_W'(fw), DIM_W'(fh));
            first = 1'b0;
         end
         sender_lazy = $urandom_range(0, 3) != 0;
         noise_kind = $urandom_range(0, 3) == 0 ? 0 : 1;
         base_level = PIX_W'($urandom);
         send_frame(fw * fh);
         random_sent += fw * fh;
      end

      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (30) @(negedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
